// File: rtl/bayer_rggb_bilinear_demosaic_defines.svh
// Assertion helpers for the demosaic RTL.
// Each takes a label, clock, active-low reset, the condition(s) and a message.
`ifndef BAYER_RGGB_BILINEAR_DEMOSAIC_DEFINES_SVH
`define BAYER_RGGB_BILINEAR_DEMOSAIC_DEFINES_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define DMSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Check cons in the cycle after ante.
`define DMSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DMSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define DMSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/dmsc_pkg.sv
`default_nettype none
package dmsc_pkg;

    // Frame limits and widths
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int DIM_W      = 13;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int SAMPLE_W   = 10;
    localparam int CHAN_W     = 8;
    localparam int RAW_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [DIM_W-1:0] MIN_DIM      = DIM_W'(2);
    localparam logic [DIM_W-1:0] MAX_W_DIM    = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM    = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] RST_WIDTH    = DIM_W'(4096);
    localparam logic [DIM_W-1:0] RST_HEIGHT   = DIM_W'(4096);

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FRAME_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_FRAME_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_HIGH_ALIGNED = 2'd2;

    typedef logic [SAMPLE_W-1:0] t_sample;

    // Input and output words
    typedef struct packed {
        logic [RAW_W-1:0] raw_word;
        logic             drain;
    } t_in_word;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              end_of_line;
        logic              end_of_frame;
    } t_out_word;

    // Per-item control for the output pixel released by an item
    typedef struct packed {
        logic emit;
        logic x_first;
        logic x_last;
        logic y_first;
        logic y_last;
        logic x_odd;
        logic y_odd;
        logic eol;
        logic eof;
    } t_pix_ctrl;

    // What the front end issues into the line-store stage
    typedef struct packed {
        t_pix_ctrl         ctrl;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        t_sample           sample;
    } t_issue;

    // One window column: rows y-1, y, y+1
    typedef struct packed {
        t_sample top;
        t_sample mid;
        t_sample bot;
    } t_column;

    // Interpolated 10-bit pixel
    typedef struct packed {
        t_sample r;
        t_sample g;
        t_sample b;
        logic    eol;
        logic    eof;
    } t_rgb10;

endpackage
`default_nettype wire

// File: rtl/bayer_rggb_bilinear_demosaic.sv
// Path: the input word that releases a result (the word width+1 positions later in raster
// order) passes the line-store, window and interpolation stages into the output register.
// Throughput: one word per cycle in and out unless the output stalls; each line store
// takes one read and one write per cycle; the pipeline fills bubbles under output stall.
// Reset (synchronous, active low) clears counters, stage valids and window, resets the
// configuration; line stores are not cleared, every entry is written before it is used.
`default_nettype none
`include "bayer_rggb_bilinear_demosaic_defines.svh"
module bayer_rggb_bilinear_demosaic (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire dmsc_pkg::t_cfg_idx              i_cfg_index,
    input  wire logic [dmsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output      logic                            o_in_stall,
    input  wire dmsc_pkg::t_in_word              i_in_word,
    output      logic                            o_out_valid,
    input  wire logic                            i_out_stall,
    output      dmsc_pkg::t_out_word             o_out_word
);
    import dmsc_pkg::*;

    logic      r_s1_valid;
    t_issue    r_s1;
    logic      r_s2_valid;
    logic      r_s3_valid;
    t_rgb10    r_s3;
    logic      r_out_valid;
    t_out_word r_out;

    t_issue    issue;
    logic      ignore;
    logic      accept;
    logic      load_s1;
    logic      load_s2;
    logic      leave_s2;
    logic      load_s3;
    logic      load_out;
    logic      out_ready;
    logic      s3_ready;
    logic      s2_ready;
    logic      s1_ready;
    logic      lb_we;
    t_sample   row_prev;
    t_sample   row_prev2;
    t_column   column;
    t_pix_ctrl s2_ctrl;
    t_rgb10    s2_rgb;

    // Scale a 10-bit channel to 8 bits: (v*255+511)/1023, divide by reciprocal
    function automatic logic [CHAN_W-1:0] f_scale(input t_sample v);
        logic [17:0] num;
        logic [17:0] quo;
        num = {v, 8'b0} - {8'b0, v} + 18'd511;
        quo = num + (num >> 10) + 18'd1;
        return quo[17:10];
    endfunction

    // Ready chain from the output back to the input
    always_comb begin
        out_ready  = !r_out_valid || !i_out_stall;
        s3_ready   = !r_s3_valid || out_ready;
        s2_ready   = !r_s2_valid || !s2_ctrl.emit || s3_ready;
        s1_ready   = !r_s1_valid || s2_ready;
        o_in_stall = !s1_ready;
        accept     = i_in_valid && s1_ready;
        load_s1    = accept && !ignore;
        load_s2    = r_s1_valid && s2_ready;
        leave_s2   = r_s2_valid && (!s2_ctrl.emit || s3_ready);
        load_s3    = r_s2_valid && s2_ctrl.emit && s3_ready;
        load_out   = r_s3_valid && out_ready;
        lb_we      = load_s2 && r_s1.wr;
    end

    dmsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_load      (load_s1),
        .o_ignore    (ignore),
        .o_issue     (issue)
    );

    // Line store holding the previous row
    dmsc_line_ram u_lb_prev (
        .i_clk   (i_clk),
        .i_we    (lb_we),
        .i_waddr (r_s1.addr),
        .i_wdata (r_s1.sample),
        .i_re    (load_s1),
        .i_raddr (issue.addr),
        .o_rdata (row_prev)
    );

    // Line store holding the row before that, fed from the first
    dmsc_line_ram u_lb_prev2 (
        .i_clk   (i_clk),
        .i_we    (lb_we),
        .i_waddr (r_s1.addr),
        .i_wdata (row_prev),
        .i_re    (load_s1),
        .i_raddr (issue.addr),
        .o_rdata (row_prev2)
    );

    // Line-store stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= load_s1 || (r_s1_valid && !load_s2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_s1) begin
            r_s1 <= issue;
        end
    end

    assign column.top = row_prev2;
    assign column.mid = row_prev;
    assign column.bot = r_s1.sample;

    dmsc_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load_s2),
        .i_ctrl   (r_s1.ctrl),
        .i_column (column),
        .o_ctrl   (s2_ctrl),
        .o_rgb    (s2_rgb)
    );

    // Window stage, interpolation stage and output register valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s2_valid  <= load_s2 || (r_s2_valid && !leave_s2);
            r_s3_valid  <= load_s3 || (r_s3_valid && !load_out);
            r_out_valid <= load_out || (r_out_valid && i_out_stall);
        end
    end

    // Hold the interpolated pixel
    always_ff @(posedge i_clk) begin
        if (load_s3) begin
            r_s3 <= s2_rgb;
        end
    end

    // Scale to 8 bits into the output register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.red          <= f_scale(r_s3.r);
            r_out.green        <= f_scale(r_s3.g);
            r_out.blue         <= f_scale(r_s3.b);
            r_out.end_of_line  <= r_s3.eol;
            r_out.end_of_frame <= r_s3.eof;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `DMSC_ASSERT_IMPLY(a_lb_ports_apart, i_clk, i_rst_n, load_s1 && lb_we, issue.addr != r_s1.addr, "line store read and write hit the same entry")
    `DMSC_ASSERT_IMPLY(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, r_s1_valid && r_s2_valid && r_s3_valid && r_out_valid && i_out_stall, "input stalled with room in the pipeline")
    `DMSC_ASSERT_NEXT(a_out_load_flags, i_clk, i_rst_n, load_out, o_out_valid && (o_out_word.end_of_line == $past(r_s3.eol)) && (o_out_word.end_of_frame == $past(r_s3.eof)), "output word flags do not follow the interpolation stage")

endmodule
`default_nettype wire

// File: rtl/dmsc_line_ram.sv
`default_nettype none
module dmsc_line_ram (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [dmsc_pkg::ADDR_W-1:0] i_waddr,
    input  wire dmsc_pkg::t_sample        i_wdata,
    input  wire logic                     i_re,
    input  wire logic [dmsc_pkg::ADDR_W-1:0] i_raddr,
    output      dmsc_pkg::t_sample        o_rdata
);
    import dmsc_pkg::*;

    t_sample r_mem [MAX_WIDTH];
    t_sample r_rdata;

    // Write one sample per cycle while write is enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: rtl/dmsc_ctrl.sv
`default_nettype none
module dmsc_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire dmsc_pkg::t_cfg_idx            i_cfg_index,
    input  wire logic [dmsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire dmsc_pkg::t_in_word            i_in_word,
    input  wire logic                          i_load,
    output      logic                          o_ignore,
    output      dmsc_pkg::t_issue              o_issue
);
    import dmsc_pkg::*;

    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic             r_high_aligned;

    logic [DIM_W-1:0] r_in_col, n_in_col;
    logic [DIM_W-1:0] r_in_row, n_in_row;
    logic [DIM_W-1:0] r_out_col, n_out_col;
    logic [DIM_W-1:0] r_out_row, n_out_row;

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [DIM_W-1:0] w_last;
    logic [DIM_W-1:0] h_last;
    logic             pixel_phase;
    logic             restart;
    logic             emit;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic [DIM_W:0]   in_col_inc;
    logic [DIM_W:0]   out_col_inc;
    logic [DIM_W:0]   out_row_inc;
    logic             eol;
    logic             eof;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_WIDTH;
            r_frame_height <= RST_HEIGHT;
            r_high_aligned <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                CFG_HIGH_ALIGNED: r_high_aligned <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp frame size into the supported range
    always_comb begin
        if (r_frame_width < MIN_DIM) begin
            w_eff = MIN_DIM;
        end else if (r_frame_width > MAX_W_DIM) begin
            w_eff = MAX_W_DIM;
        end else begin
            w_eff = r_frame_width;
        end
        if (r_frame_height < MIN_DIM) begin
            h_eff = MIN_DIM;
        end else if (r_frame_height > MAX_H_DIM) begin
            h_eff = MAX_H_DIM;
        end else begin
            h_eff = r_frame_height;
        end
        w_last = w_eff - DIM_W'(1);
        h_last = h_eff - DIM_W'(1);
    end

    // Input position, warm-up and drain handling
    always_comb begin
        pixel_phase = r_in_row < h_eff;
        o_ignore    = pixel_phase && i_in_word.drain;
        col         = (r_in_col < w_eff) ? r_in_col : w_last;
        in_col_inc  = {1'b0, r_in_col} + (DIM_W+1)'(1);
        restart     = 1'b0;
        n_in_col    = in_col_inc[DIM_W-1:0];
        n_in_row    = r_in_row;
        if (pixel_phase) begin
            emit = (r_in_row >= DIM_W'(2)) || ((r_in_row == DIM_W'(1)) && (r_in_col != '0));
            if (in_col_inc >= {1'b0, w_eff}) begin
                n_in_col = '0;
                n_in_row = r_in_row + DIM_W'(1);
            end
        end else begin
            emit    = 1'b1;
            restart = in_col_inc > {1'b0, w_eff};
        end
    end

    // Output position and border flags of the released pixel
    always_comb begin
        x           = (r_out_col < w_eff) ? r_out_col : w_last;
        y           = (r_out_row < h_eff) ? r_out_row : h_last;
        out_col_inc = {1'b0, r_out_col} + (DIM_W+1)'(1);
        out_row_inc = {1'b0, r_out_row} + (DIM_W+1)'(1);
        eol         = out_col_inc >= {1'b0, w_eff};
        eof         = eol && (out_row_inc >= {1'b0, h_eff});
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        if (emit) begin
            if (eol) begin
                n_out_col = '0;
                n_out_row = out_row_inc[DIM_W-1:0];
            end else begin
                n_out_col = out_col_inc[DIM_W-1:0];
            end
        end
    end

    // Issue word for the line-store stage
    always_comb begin
        o_issue.ctrl.emit    = emit;
        o_issue.ctrl.x_first = x == '0;
        o_issue.ctrl.x_last  = x == w_last;
        o_issue.ctrl.y_first = y == '0;
        o_issue.ctrl.y_last  = y == h_last;
        o_issue.ctrl.x_odd   = x[0];
        o_issue.ctrl.y_odd   = y[0];
        o_issue.ctrl.eol     = eol;
        o_issue.ctrl.eof     = eof;
        o_issue.wr           = pixel_phase;
        o_issue.addr         = col[ADDR_W-1:0];
        o_issue.sample       = r_high_aligned ? i_in_word.raw_word[RAW_W-1:RAW_W-SAMPLE_W]
                                              : i_in_word.raw_word[SAMPLE_W-1:0];
    end

    // Advance counters on each loaded word, restart after the drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_load) begin
            if (restart) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                r_in_col  <= n_in_col;
                r_in_row  <= n_in_row;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/dmsc_window.sv
`default_nettype none
module dmsc_window (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire dmsc_pkg::t_pix_ctrl i_ctrl,
    input  wire dmsc_pkg::t_column   i_column,
    output      dmsc_pkg::t_pix_ctrl o_ctrl,
    output      dmsc_pkg::t_rgb10    o_rgb
);
    import dmsc_pkg::*;

    t_column   r_col_l;
    t_column   r_col_c;
    t_column   r_col_r;
    t_pix_ctrl r_ctrl;

    t_column   col_l;
    t_column   col_r;
    t_sample   c;
    t_sample   west;
    t_sample   east;
    t_sample   north;
    t_sample   south;
    t_sample   nw;
    t_sample   ne;
    t_sample   sw;
    t_sample   se;
    logic [SAMPLE_W+1:0] cross_sum;
    logic [SAMPLE_W+1:0] diag_sum;
    logic [SAMPLE_W:0]   horiz_sum;
    logic [SAMPLE_W:0]   vert_sum;
    t_sample   cross_avg;
    t_sample   diag_avg;
    t_sample   horiz_avg;
    t_sample   vert_avg;

    // Shift the 3x3 window by one column per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_l <= '0;
            r_col_c <= '0;
            r_col_r <= '0;
        end else if (i_load) begin
            r_col_l <= r_col_c;
            r_col_c <= r_col_r;
            r_col_r <= i_column;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ctrl <= i_ctrl;
        end
    end

    // Replicate edge samples at the frame borders
    always_comb begin
        col_l = r_ctrl.x_first ? r_col_c : r_col_l;
        col_r = r_ctrl.x_last  ? r_col_c : r_col_r;
        c     = r_col_c.mid;
        west  = col_l.mid;
        east  = col_r.mid;
        north = r_ctrl.y_first ? r_col_c.mid : r_col_c.top;
        south = r_ctrl.y_last  ? r_col_c.mid : r_col_c.bot;
        nw    = r_ctrl.y_first ? col_l.mid : col_l.top;
        ne    = r_ctrl.y_first ? col_r.mid : col_r.top;
        sw    = r_ctrl.y_last  ? col_l.mid : col_l.bot;
        se    = r_ctrl.y_last  ? col_r.mid : col_r.bot;
    end

    // Neighbor averages, truncated
    always_comb begin
        horiz_sum = {1'b0, west} + {1'b0, east};
        vert_sum  = {1'b0, north} + {1'b0, south};
        cross_sum = {1'b0, horiz_sum} + {1'b0, vert_sum};
        diag_sum  = ({2'b0, nw} + {2'b0, ne}) + ({2'b0, sw} + {2'b0, se});
        horiz_avg = horiz_sum[SAMPLE_W:1];
        vert_avg  = vert_sum[SAMPLE_W:1];
        cross_avg = cross_sum[SAMPLE_W+1:2];
        diag_avg  = diag_sum[SAMPLE_W+1:2];
    end

    // Pick channels by Bayer phase: R at even/even, B at odd/odd
    always_comb begin
        o_rgb.eol = r_ctrl.eol;
        o_rgb.eof = r_ctrl.eof;
        case ({r_ctrl.y_odd, r_ctrl.x_odd})
            2'b00: begin
                o_rgb.r = c;
                o_rgb.g = cross_avg;
                o_rgb.b = diag_avg;
            end
            2'b01: begin
                o_rgb.r = horiz_avg;
                o_rgb.g = c;
                o_rgb.b = vert_avg;
            end
            2'b10: begin
                o_rgb.r = vert_avg;
                o_rgb.g = c;
                o_rgb.b = horiz_avg;
            end
            default: begin
                o_rgb.r = diag_avg;
                o_rgb.g = cross_avg;
                o_rgb.b = c;
            end
        endcase
    end

    assign o_ctrl = r_ctrl;

endmodule
`default_nettype wire

// File: bench/bayer_rggb_bilinear_demosaic_test.sv
`timescale 1ns / 1ps
module bayer_rggb_bilinear_demosaic_test;
    import dmsc_pkg::*;

    localparam int        CYCLE_LIMIT = 400000;
    localparam int        RANDOM_WORDS = 1200;
    localparam int        SETTLE_CYCLES = 8;
    localparam t_cfg_idx  CFG_UNUSED = t_cfg_idx'(3);

    // Shadow of the demosaic: four row slots, frame counters and the queue of
    // pixels still owed by the block.
    class pixel_scoreboard;
        t_sample             rows [4][MAX_WIDTH];
        logic [DIM_W-1:0]    width_reg;
        logic [DIM_W-1:0]    height_reg;
        logic                high_aligned;
        int unsigned         col_in, row_in, col_out, row_out;
        t_out_word           pending_pixels [$];
        int                  errors;

        function new();
            width_reg = RST_WIDTH;
            height_reg = RST_HEIGHT;
            high_aligned = 1'b0;
            col_in = 0;
            row_in = 0;
            col_out = 0;
            row_out = 0;
            errors = 0;
        endfunction

        function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned top);
            return v < 2 ? 2 : (v > top ? top : v);
        endfunction

        function int unsigned cols();
            return clamp_dim(width_reg, MAX_WIDTH);
        endfunction

        function int unsigned lines();
            return clamp_dim(height_reg, MAX_HEIGHT);
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_FRAME_WIDTH:  width_reg = d;
                CFG_FRAME_HEIGHT: height_reg = d;
                CFG_HIGH_ALIGNED: high_aligned = d[0];
                default: ;
            endcase
        endfunction

        // Read a sample with the coordinates clamped into the frame
        function int fetch(int x, int y, int wd, int ht);
            if (x < 0) x = 0;
            if (x >= wd) x = wd - 1;
            if (y < 0) y = 0;
            if (y >= ht) y = ht - 1;
            return rows[y % 4][x];
        endfunction

        function logic [CHAN_W-1:0] scale8(int v);
            return CHAN_W'(((v & 'h3FF) * 255 + 511) / 1023);
        endfunction

        // Bilinear RGB of the next output pixel; queue it and advance
        function void interpolate_pixel(int wd, int ht);
            int        x = col_out < wd ? col_out : wd - 1;
            int        y = row_out < ht ? row_out : ht - 1;
            int        c = fetch(x, y, wd, ht);
            int        lf = fetch(x - 1, y, wd, ht);
            int        rt = fetch(x + 1, y, wd, ht);
            int        up = fetch(x, y - 1, wd, ht);
            int        dn = fetch(x, y + 1, wd, ht);
            int        cross_sum = lf + rt + up + dn;
            int        diag = fetch(x - 1, y - 1, wd, ht) + fetch(x + 1, y - 1, wd, ht)
                            + fetch(x - 1, y + 1, wd, ht) + fetch(x + 1, y + 1, wd, ht);
            int        r, g, b;
            t_out_word px;
            if (y % 2 == 0 && x % 2 == 0) begin
                r = c; g = cross_sum / 4; b = diag / 4;
            end else if (y % 2 == 0) begin
                g = c; r = (lf + rt) / 2; b = (up + dn) / 2;
            end else if (x % 2 == 0) begin
                g = c; r = (up + dn) / 2; b = (lf + rt) / 2;
            end else begin
                b = c; g = cross_sum / 4; r = diag / 4;
            end
            px.red = scale8(r);
            px.green = scale8(g);
            px.blue = scale8(b);
            px.end_of_line = col_out + 1 >= wd;
            px.end_of_frame = col_out + 1 >= wd && row_out + 1 >= ht;
            pending_pixels.push_back(px);
            col_out++;
            if (col_out >= wd) begin
                col_out = 0;
                row_out++;
            end
        endfunction

        // Note one accepted input word
        function void take_sample(t_in_word w);
            int unsigned wd = cols();
            int unsigned ht = lines();
            bit          fire;
            bit          restart = 1'b0;
            if (row_in < ht) begin
                // drain flag while pixels are due: dropped without effect
                if (w.drain) return;
                rows[row_in % 4][col_in < wd ? col_in : wd - 1] =
                    high_aligned ? w.raw_word[15:6] : w.raw_word[9:0];
                fire = row_in >= 2 || (row_in == 1 && col_in >= 1);
                col_in++;
                if (col_in >= wd) begin
                    col_in = 0;
                    row_in++;
                end
            end else begin
                // flush phase: every word releases a pixel, the payload is dropped
                fire = 1'b1;
                col_in++;
                if (col_in > wd) restart = 1'b1;
            end
            if (fire) interpolate_pixel(wd, ht);
            if (restart) begin
                col_in = 0;
                row_in = 0;
                col_out = 0;
                row_out = 0;
            end
        endfunction

        function void check_field(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void compare_pixel(t_out_word got);
            t_out_word want;
            if (pending_pixels.size() == 0) begin
                $error("result word with no pixel expected");
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            check_field("red", want.red, got.red);
            check_field("green", want.green, got.green);
            check_field("blue", want.blue, got.blue);
            check_field("end_of_line", CHAN_W'(want.end_of_line), CHAN_W'(got.end_of_line));
            check_field("end_of_frame", CHAN_W'(want.end_of_frame), CHAN_W'(got.end_of_frame));
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    t_cfg_idx                i_cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    t_in_word                i_in_word = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    t_out_word               o_out_word;

    pixel_scoreboard         lineup;
    bit                      steady = 1'b0;
    int                      cycles = 0;

    bayer_rggb_bilinear_demosaic dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Take result words and stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) lineup.compare_pixel(o_out_word);
        i_out_stall <= !steady && $urandom_range(99) < 17;
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        lineup.write_reg(idx, d);
    endtask

    task automatic set_format(input logic [DIM_W-1:0] wreg, input logic [DIM_W-1:0] hreg,
                              input logic [CFG_DATA_W-1:0] align);
        write_reg(CFG_FRAME_WIDTH, wreg);
        write_reg(CFG_FRAME_HEIGHT, hreg);
        write_reg(CFG_HIGH_ALIGNED, align);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one word, with random idle cycles ahead of it, and hold it until taken
    task automatic push_word(input logic [RAW_W-1:0] raw, input logic drn);
        t_in_word w;
        w.raw_word = raw;
        w.drain = drn;
        while (!steady && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        lineup.take_sample(w);
    endtask

    // Hold off input until every owed pixel is out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (lineup.pending_pixels.size() != 0);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One frame of random samples, stray drain flags, maybe a pause, flush words
    task automatic stream_frame();
        int unsigned wd = lineup.cols();
        int unsigned ht = lineup.lines();
        int          pause_at = $urandom_range(3) == 0 ? $urandom_range(wd * ht - 1) : -1;
        for (int n = 0; n < wd * ht; n++) begin
            if (n == pause_at) wait_drained();
            if ($urandom_range(99) < 6) push_word(RAW_W'($urandom), 1'b1);
            push_word(RAW_W'($urandom), 1'b0);
        end
        for (int n = 0; n <= wd; n++) push_word(RAW_W'($urandom), $urandom_range(99) >= 25);
    endtask

    initial begin
        logic [RAW_W-1:0]  corner [9];
        int                fed;
        logic [DIM_W-1:0]  wreg, hreg;

        corner = '{16'hFFC0, 16'h0000, 16'hFFFF, 16'h003F, 16'hFFC0,
                   16'h0040, 16'h8000, 16'h7FFF, 16'hFFFF};
        fed = 0;
        lineup = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest frame, sizes below the minimum, sample extremes, a stray
        // drain flag mid-frame and a pixel word during the flush
        write_reg(CFG_UNUSED, 13'h1FFF);
        set_format(13'd1, 13'd0, 13'd0);
        push_word(16'h0000, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(16'hFFFF, 1'b1);
        push_word(16'h03FF, 1'b0);
        push_word(16'hFC00, 1'b0);
        push_word(16'hFFFF, 1'b1);
        push_word(16'h1234, 1'b0);
        push_word(16'h0000, 1'b1);
        settle();

        // High alignment, written with junk above the flag bit
        set_format(13'd3, 13'd3, 13'h1FFF);
        foreach (corner[i]) push_word(corner[i], 1'b0);
        repeat (4) push_word(16'hFFFF, 1'b1);
        settle();

        // Random frames, mostly small, with a stretch of back-to-back traffic
        while (fed < RANDOM_WORDS) begin
            case ($urandom_range(9))
                0:       wreg = DIM_W'($urandom_range(1));
                1:       wreg = DIM_W'($urandom_range(40, 13));
                default: wreg = DIM_W'($urandom_range(12, 2));
            endcase
            case ($urandom_range(9))
                0:       hreg = DIM_W'($urandom_range(1));
                1:       hreg = DIM_W'($urandom_range(20, 9));
                default: hreg = DIM_W'($urandom_range(8, 2));
            endcase
            set_format(wreg, hreg, {12'($urandom), 1'($urandom)});
            steady = fed >= 400 && fed < 700;
            fed += lineup.cols() * lineup.lines() + lineup.cols() + 1;
            stream_frame();
            settle();
        end
        steady = 1'b0;

        if (lineup.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: bayer_rggb_bilinear_demosaic.f
+incdir+rtl
rtl/dmsc_pkg.sv
rtl/dmsc_line_ram.sv
rtl/dmsc_ctrl.sv
rtl/dmsc_window.sv
rtl/bayer_rggb_bilinear_demosaic.sv
bench/bayer_rggb_bilinear_demosaic_test.sv
